// File: rtl/vau_pkg.sv
package vau_pkg;

	// Element conversion family of a format
	typedef enum logic [2:0] {
		K_NONE, K_UNORM, K_UINT, K_SNORM, K_SINT, K_HALF, K_FLOAT, K_PACKED
	} kind_t;

	// Per-lane conversion operation
	typedef enum logic [3:0] {
		LOP_ZERO, LOP_UN8, LOP_UN16, LOP_SN8, LOP_SN16, LOP_PK10,
		LOP_UINT, LOP_SI8, LOP_SI16, LOP_SI32, LOP_PK2, LOP_HALF, LOP_FLOAT
	} lop_t;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] size;
		logic [2:0] count;
	} fmt_t;

	// Stage enables handed to each lane
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} lane_en_t;

	localparam int NumLanes = 4;

	// Format table, indexed by format code; unknown codes read as empty
	localparam fmt_t FMT_TABLE [64] = '{
		0:  '{K_PACKED, 3'd4, 3'd1},
		1:  '{K_UNORM, 3'd1, 3'd1}, 2:  '{K_UINT, 3'd1, 3'd1}, 3:  '{K_SNORM, 3'd1, 3'd1},
		4:  '{K_SINT, 3'd1, 3'd1},  5:  '{K_SINT, 3'd1, 3'd1}, 6:  '{K_UINT, 3'd1, 3'd1},
		7:  '{K_UNORM, 3'd2, 3'd1}, 8:  '{K_UINT, 3'd2, 3'd1}, 9:  '{K_SNORM, 3'd2, 3'd1},
		10: '{K_SINT, 3'd2, 3'd1},  11: '{K_SINT, 3'd2, 3'd1}, 12: '{K_UINT, 3'd2, 3'd1},
		13: '{K_UNORM, 3'd1, 3'd2}, 14: '{K_UINT, 3'd1, 3'd2}, 15: '{K_SNORM, 3'd1, 3'd2},
		16: '{K_SINT, 3'd1, 3'd2},  17: '{K_SINT, 3'd1, 3'd2}, 18: '{K_UINT, 3'd1, 3'd2},
		19: '{K_UNORM, 3'd1, 3'd4}, 20: '{K_UINT, 3'd1, 3'd4}, 21: '{K_SNORM, 3'd1, 3'd4},
		22: '{K_SINT, 3'd1, 3'd4},  23: '{K_SINT, 3'd1, 3'd4}, 24: '{K_UINT, 3'd1, 3'd4},
		25: '{K_UNORM, 3'd2, 3'd2}, 26: '{K_UINT, 3'd2, 3'd2}, 27: '{K_SNORM, 3'd2, 3'd2},
		28: '{K_SINT, 3'd2, 3'd2},  29: '{K_SINT, 3'd2, 3'd2}, 30: '{K_UINT, 3'd2, 3'd2},
		31: '{K_HALF, 3'd2, 3'd2},  32: '{K_HALF, 3'd2, 3'd4},
		33: '{K_UINT, 3'd4, 3'd1},  34: '{K_SINT, 3'd4, 3'd1}, 35: '{K_FLOAT, 3'd4, 3'd1},
		36: '{K_UINT, 3'd4, 3'd2},  37: '{K_SINT, 3'd4, 3'd2}, 38: '{K_FLOAT, 3'd4, 3'd2},
		39: '{K_UINT, 3'd4, 3'd3},  40: '{K_SINT, 3'd4, 3'd3}, 41: '{K_FLOAT, 3'd4, 3'd3},
		42: '{K_UINT, 3'd4, 3'd4},  43: '{K_SINT, 3'd4, 3'd4}, 44: '{K_FLOAT, 3'd4, 3'd4},
		default: '{K_NONE, 3'd0, 3'd0}
	};

	// Byte of the 16-byte stream
	function automatic logic [7:0] stream_byte(input logic [127:0] raw, input logic [3:0] idx);
		return raw[{idx, 3'b000} +: 8];
	endfunction

	// Element of 1, 2 or 4 bytes at a byte offset
	function automatic logic [31:0] read_elem(input logic [127:0] raw, input logic [3:0] off,
	                                          input logic [2:0] size, input logic be);
		logic [7:0] b0, b1, b2, b3;
		logic [31:0] v;
		b0 = stream_byte(raw, off);
		b1 = stream_byte(raw, off + 4'd1);
		b2 = stream_byte(raw, off + 4'd2);
		b3 = stream_byte(raw, off + 4'd3);
		case (size)
			3'd1: v = {24'd0, b0};
			3'd2: v = be ? {16'd0, b0, b1} : {16'd0, b1, b0};
			3'd4: v = be ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/vau_if.sv
interface vau_in_if;
	logic        valid;
	logic        ready;
	logic [5:0]  mode;
	logic [63:0] raw_low;
	logic [63:0] raw_high;

	modport source(output valid, mode, raw_low, raw_high, input ready);
	modport sink(input valid, mode, raw_low, raw_high, output ready);
endinterface

interface vau_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] x_bits;
	logic [31:0] y_bits;
	logic [31:0] z_bits;
	logic [31:0] w_bits;
	logic [4:0]  bytes_used;

	modport source(output valid, x_bits, y_bits, z_bits, w_bits, bytes_used, input ready);
	modport sink(input valid, x_bits, y_bits, z_bits, w_bits, bytes_used, output ready);
endinterface

// File: rtl/vau_lane.sv
module vau_lane (
	input  logic              clk,
	input  vau_pkg::lane_en_t en,
	input  vau_pkg::lop_t     op,
	input  logic [31:0]       val,
	output logic [31:0]       res
);
	import vau_pkg::*;

	// Bits of r/(2^k-1): the k-bit remainder repeats forever
	function automatic logic [47:0] rep_frac(input logic [15:0] r, input lop_t o);
		logic [48:0] t49;
		logic [53:0] t54;
		logic [59:0] t60;
		logic [47:0] f;
		t49 = {7{r[6:0]}};
		t54 = {6{r[8:0]}};
		t60 = {4{r[14:0]}};
		case (o)
			LOP_UN8:  f = {6{r[7:0]}};
			LOP_UN16: f = {3{r[15:0]}};
			LOP_SN8:  f = t49[48:1];
			LOP_SN16: f = t60[59:12];
			LOP_PK10: f = t54[53:6];
			default:  f = 48'd0;
		endcase
		return f;
	endfunction

	// Stage 1 decode
	logic [32:0] n, a;
	logic [16:0] d;
	logic        is_norm, is_int, neg, q;
	logic [15:0] r;
	logic [48:0] mag;
	logic [7:0]  base;
	logic        pass, psign;
	logic [31:0] pbits;
	logic [4:0]  he;

	always_comb begin
		n = 33'd0;
		d = 17'd0;
		is_norm = 1'b0;
		is_int = 1'b0;
		case (op)
			LOP_UN8:  begin n = {25'd0, val[7:0]}; d = 17'd255; is_norm = 1'b1; end
			LOP_UN16: begin n = {17'd0, val[15:0]}; d = 17'd65535; is_norm = 1'b1; end
			LOP_SN8:  begin n = {{25{val[7]}}, val[7:0]}; d = 17'd127; is_norm = 1'b1; end
			LOP_SN16: begin n = {{17{val[15]}}, val[15:0]}; d = 17'd32767; is_norm = 1'b1; end
			LOP_PK10: begin n = {{23{val[9]}}, val[9:0]}; d = 17'd511; is_norm = 1'b1; end
			LOP_UINT: begin n = {1'b0, val}; is_int = 1'b1; end
			LOP_SI8:  begin n = {{25{val[7]}}, val[7:0]}; is_int = 1'b1; end
			LOP_SI16: begin n = {{17{val[15]}}, val[15:0]}; is_int = 1'b1; end
			LOP_SI32: begin n = {val[31], val}; is_int = 1'b1; end
			LOP_PK2:  begin n = {{31{val[1]}}, val[1:0]}; is_int = 1'b1; end
			default:  begin n = 33'd0; end
		endcase
		neg = n[32];
		a = neg ? (~n + 33'd1) : n;
		// quotient is at most one since |n| <= d + 1
		q = a[16:0] >= d;
		r = q ? 16'(a[16:0] - d) : a[15:0];

		he = val[14:10];
		pass = 1'b1;
		psign = neg;
		pbits = 32'd0;
		mag = 49'd0;
		base = 8'd127;
		if (is_norm) begin
			pass = 1'b0;
			mag = {q, rep_frac(r, op)};
			base = 8'd127;
		end else if (is_int) begin
			pass = 1'b0;
			mag = {16'd0, a};
			base = 8'd175;
		end else if (op == LOP_FLOAT) begin
			pbits = val;
		end else if (op == LOP_HALF) begin
			psign = val[15];
			if (he == 5'd0 && val[9:0] == 10'd0) begin
				pbits = {val[15], 31'd0};
			end else if (he == 5'd0) begin
				// subnormal half: mantissa times 2^-24 through the normalizer
				pass = 1'b0;
				mag = {39'd0, val[9:0]};
				base = 8'd151;
			end else if (he == 5'h1F) begin
				pbits = {val[15], 8'hFF, val[9:0], 13'd0};
			end else begin
				pbits = {val[15], 8'({3'd0, he} + 8'd112), val[9:0], 13'd0};
			end
		end
	end

	logic        sign_s1, pass_s1, stk_s1;
	logic [48:0] mag_s1;
	logic [7:0]  base_s1;
	logic [31:0] pbits_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sign_s1 <= psign;
			pass_s1 <= pass;
			stk_s1 <= is_norm && (r != 16'd0);
			mag_s1 <= mag;
			base_s1 <= base;
			pbits_s1 <= pbits;
		end
	end

	// Stage 2: leading zero count
	logic [5:0] lz;
	always_comb begin
		lz = 6'd0;
		for (int i = 0; i < 49; i++) begin
			if (mag_s1[i]) lz = 6'(48 - i);
		end
	end

	logic        sign_s2, pass_s2, stk_s2, zero_s2;
	logic [48:0] mag_s2;
	logic [7:0]  base_s2;
	logic [31:0] pbits_s2;
	logic [5:0]  lz_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sign_s2 <= sign_s1;
			pass_s2 <= pass_s1;
			stk_s2 <= stk_s1;
			zero_s2 <= mag_s1 == 49'd0;
			mag_s2 <= mag_s1;
			base_s2 <= base_s1;
			pbits_s2 <= pbits_s1;
			lz_s2 <= lz;
		end
	end

	// Stage 3: normalize
	logic        sign_s3, pass_s3, stk_s3, zero_s3;
	logic [48:0] m_s3;
	logic [7:0]  exp_s3;
	logic [31:0] pbits_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sign_s3 <= sign_s2;
			pass_s3 <= pass_s2;
			stk_s3 <= stk_s2;
			zero_s3 <= zero_s2;
			m_s3 <= mag_s2 << lz_s2;
			exp_s3 <= base_s2 - {2'd0, lz_s2};
			pbits_s3 <= pbits_s2;
		end
	end

	// Stage 4: round to nearest even and pack
	logic        guard, sticky, rnd;
	logic [24:0] mant;
	logic [7:0]  exp_f;
	logic [22:0] frac;
	logic [31:0] packed_v;

	always_comb begin
		guard = m_s3[24];
		sticky = (m_s3[23:0] != 24'd0) || stk_s3;
		rnd = guard && (sticky || m_s3[25]);
		mant = {1'b0, 1'b1, m_s3[47:25]} + {24'd0, rnd};
		exp_f = exp_s3 + {7'd0, mant[24]};
		frac = mant[24] ? 23'd0 : mant[22:0];
		if (pass_s3) packed_v = pbits_s3;
		else if (zero_s3) packed_v = {sign_s3, 31'd0};
		else packed_v = {sign_s3, exp_f, frac};
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			res <= packed_v;
		end
	end

endmodule

// File: rtl/vertex_attribute_unpack.sv
// Vertex attribute unpack: one raw attribute in, four single-precision components out.
// Input channel attr_in carries a format code and 16 stream bytes (raw_low holds
// bytes 0..7, raw_high bytes 8..15, lowest byte in the low bits). Output channel
// attr_out returns x/y/z/w as IEEE single bit patterns plus the bytes consumed.
// Both channels transfer on valid && ready.
// cfg_we/cfg_wdata write the byte order flag (1 = most significant byte first for
// 16- and 32-bit elements; half floats are always little-endian); write only while idle.
// One item per cycle is sustained while attr_out.ready stays high. Each of the
// four lanes registers decode, leading zero count, normalize shift and round/pack,
// one register stage apiece.
// Each stage advances when the next is empty or advancing, so a stalled receiver
// keeps its result in the output register while up to three more items fill the
// earlier stages before attr_in.ready drops.
// Reset clears all stage valid bits and sets little-endian order.
module vertex_attribute_unpack (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	vau_in_if.sink    attr_in,
	vau_out_if.source attr_out
);
	import vau_pkg::*;

	logic big_endian_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b0;
		end else if (cfg_we) begin
			big_endian_q <= cfg_wdata;
		end
	end

	// Stage flow control
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	lane_en_t en;

	assign rdy4 = !v_s4 || attr_out.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign en = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};
	assign attr_in.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= attr_in.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Format decode
	fmt_t         fmt;
	logic [127:0] raw;
	logic [31:0]  pk_word;
	logic         be_eff;

	assign fmt = FMT_TABLE[attr_in.mode];
	assign raw = {attr_in.raw_high, attr_in.raw_low};
	assign pk_word = read_elem(raw, 4'd0, 3'd4, big_endian_q);
	assign be_eff = big_endian_q && (fmt.kind != K_HALF);

	// Lane element select and conversion
	logic [31:0] res [NumLanes];

	for (genvar j = 0; j < NumLanes; j++) begin : g_lane
		lop_t        op;
		logic [31:0] elem;
		logic [3:0]  off;

		assign off = 4'(j * fmt.size);

		always_comb begin
			op = LOP_ZERO;
			elem = read_elem(raw, off, fmt.size, be_eff);
			if (fmt.kind == K_PACKED) begin
				elem = pk_word >> (10 * j);
				op = (j == NumLanes - 1) ? LOP_PK2 : LOP_PK10;
			end else if (3'(j) < fmt.count) begin
				case (fmt.kind)
					K_UNORM: op = (fmt.size == 3'd1) ? LOP_UN8 : LOP_UN16;
					K_SNORM: op = (fmt.size == 3'd1) ? LOP_SN8 : LOP_SN16;
					K_UINT:  op = LOP_UINT;
					K_SINT:  op = (fmt.size == 3'd1) ? LOP_SI8 :
					              (fmt.size == 3'd2) ? LOP_SI16 : LOP_SI32;
					K_HALF:  op = LOP_HALF;
					K_FLOAT: op = LOP_FLOAT;
					default: op = LOP_ZERO;
				endcase
			end
		end

		vau_lane u_lane (
			.clk (clk),
			.en  (en),
			.op  (op),
			.val (elem),
			.res (res[j])
		);
	end

	// Byte count travels alongside the lanes
	logic [4:0] used_s1, used_s2, used_s3, used_s4;
	always_ff @(posedge clk) begin
		if (rdy1) used_s1 <= {2'd0, fmt.size} * {2'd0, fmt.count};
		if (rdy2) used_s2 <= used_s1;
		if (rdy3) used_s3 <= used_s2;
		if (rdy4) used_s4 <= used_s3;
	end

	// Merge lane results onto the output channel
	assign attr_out.valid = v_s4;
	assign attr_out.x_bits = res[0];
	assign attr_out.y_bits = res[1];
	assign attr_out.z_bits = res[2];
	assign attr_out.w_bits = res[3];
	assign attr_out.bytes_used = used_s4;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import vau_pkg::*;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] w;
		logic [4:0]  used;
	} attr_res_t;

	// One directed stimulus row; typed_exp set means the expected result is given in the row
	typedef struct packed {
		logic [5:0]  mode;
		logic [63:0] lo;
		logic [63:0] hi;
		logic        typed_exp;
		attr_res_t   res;
	} dir_row_t;

	localparam int NumRandom = 880;
	localparam int CalmTail = 120;
	localparam int StallLimit = 2000;
	localparam int DrainCycles = 12;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	vau_in_if  in_ch();
	vau_out_if out_ch();

	vertex_attribute_unpack uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.attr_in(in_ch),
		.attr_out(out_ch)
	);

	logic      model_be;
	attr_res_t pending_attrs[$];
	int        fail_cnt;
	bit        calm;
	bit        stim_done;
	int        quiet_cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Double to single, round to nearest even; inputs here are zero or normal singles
	function automatic logic [31:0] to_single(real r);
		logic [63:0] b;
		logic [30:0] body;
		logic [28:0] rem;
		int e;
		b = $realtobits(r);
		if (b[62:0] == 63'd0)
			return {b[63], 31'd0};
		e = int'(b[62:52]) - 1023 + 127;
		body = {e[7:0], b[51:29]};
		rem = b[28:0];
		if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && body[0]))
			body = body + 31'd1;
		return {b[63], body};
	endfunction

	function automatic logic [31:0] half_bits(logic [15:0] h);
		logic [31:0] sgn;
		logic [4:0]  e;
		logic [10:0] m;
		int ex;
		sgn = {h[15], 31'd0};
		e = h[14:10];
		m = {1'b0, h[9:0]};
		if (e == 5'd0) begin
			if (m == 11'd0)
				return sgn;
			ex = 127 - 15 + 1;
			while (m[10] == 1'b0) begin
				m = m << 1;
				ex--;
			end
			return sgn | (32'(ex) << 23) | (32'(m[9:0]) << 13);
		end
		if (e == 5'h1F)
			return sgn | 32'h7F80_0000 | (32'(m[9:0]) << 13);
		return sgn | ((32'(e) - 32'd15 + 32'd127) << 23) | (32'(m[9:0]) << 13);
	endfunction

	function automatic logic [31:0] fetch_elem(logic [127:0] raw, int off, int size, logic be);
		logic [31:0] v;
		v = 32'd0;
		for (int i = 0; i < size; i++) begin
			if (be)
				v = (v << 8) | 32'(raw[8 * (off + i) +: 8]);
			else
				v = v | (32'(raw[8 * (off + i) +: 8]) << (8 * i));
		end
		return v;
	endfunction

	function automatic longint signed_elem(logic [31:0] v, int size);
		if (size == 1)
			return longint'($signed(v[7:0]));
		if (size == 2)
			return longint'($signed(v[15:0]));
		return longint'($signed(v));
	endfunction

	// Expected components and byte count for one attribute
	function automatic attr_res_t unpack_attr(logic [5:0] mode, logic [63:0] lo, logic [63:0] hi,
	                                          logic be);
		attr_res_t r;
		fmt_t f;
		logic [127:0] raw;
		logic [31:0] v;
		logic [31:0] comp [4];
		int size;
		int cnt;
		for (int j = 0; j < 4; j++)
			comp[j] = 32'd0;
		raw = {hi, lo};
		f = FMT_TABLE[mode];
		size = int'(f.size);
		cnt = int'(f.count);
		r.used = 5'(size * cnt);
		if (f.kind == K_PACKED) begin
			v = fetch_elem(raw, 0, 4, be);
			comp[0] = to_single(real'(longint'($signed(v[9:0]))) / 511.0);
			comp[1] = to_single(real'(longint'($signed(v[19:10]))) / 511.0);
			comp[2] = to_single(real'(longint'($signed(v[29:20]))) / 511.0);
			comp[3] = to_single(real'(longint'($signed(v[31:30]))));
		end else begin
			for (int j = 0; j < cnt; j++) begin
				v = fetch_elem(raw, j * size, size, (f.kind == K_HALF) ? 1'b0 : be);
				case (f.kind)
					K_UNORM: comp[j] = to_single(real'(longint'(v)) / (size == 1 ? 255.0 : 65535.0));
					K_SNORM: comp[j] = to_single(real'(signed_elem(v, size)) /
					                             (size == 1 ? 127.0 : 32767.0));
					K_UINT:  comp[j] = to_single(real'(longint'(v)));
					K_SINT:  comp[j] = to_single(real'(signed_elem(v, size)));
					K_HALF:  comp[j] = half_bits(v[15:0]);
					K_FLOAT: comp[j] = v;
					default: comp[j] = 32'd0;
				endcase
			end
		end
		r.x = comp[0];
		r.y = comp[1];
		r.z = comp[2];
		r.w = comp[3];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		fail_cnt++;
	endtask

	// Output side: random stalls, checked at the falling edge before the transfer
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	always @(negedge clk) begin
		attr_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_attrs.size() == 0) begin
				report_mismatch("unexpected transfer", out_ch.x_bits, 32'd0);
			end else begin
				want = pending_attrs.pop_front();
				if (out_ch.x_bits !== want.x)
					report_mismatch("x_bits", out_ch.x_bits, want.x);
				if (out_ch.y_bits !== want.y)
					report_mismatch("y_bits", out_ch.y_bits, want.y);
				if (out_ch.z_bits !== want.z)
					report_mismatch("z_bits", out_ch.z_bits, want.z);
				if (out_ch.w_bits !== want.w)
					report_mismatch("w_bits", out_ch.w_bits, want.w);
				if (out_ch.bytes_used !== want.used)
					report_mismatch("bytes_used", 32'(out_ch.bytes_used), 32'(want.used));
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(negedge clk) begin
		if (!arst_n || stim_done || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Drive one attribute and wait for its transfer
	task automatic send_attr(logic [5:0] mode, logic [63:0] lo, logic [63:0] hi,
	                         bit typed, attr_res_t typed_res);
		attr_res_t exp_res;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.raw_low <= lo;
		in_ch.raw_high <= hi;
		forever begin
			@(negedge clk);
			if (in_ch.ready)
				break;
		end
		exp_res = typed ? typed_res : unpack_attr(mode, lo, hi, model_be);
		pending_attrs = {pending_attrs, exp_res};
		@(posedge clk);
	endtask

	task automatic write_order(logic be);
		in_ch.valid <= 1'b0;
		while (pending_attrs.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= be;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_be = be;
	endtask

	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		// sometimes force bytes to edge values
		if ($urandom_range(0, 3) == 0)
			for (int i = 0; i < 8; i++)
				case ($urandom_range(0, 5))
					0: w[8 * i +: 8] = 8'h00;
					1: w[8 * i +: 8] = 8'hFF;
					2: w[8 * i +: 8] = 8'h80;
					3: w[8 * i +: 8] = 8'h7F;
					default: ;
				endcase
		return w;
	endfunction

	// Stimulus
	initial begin
		dir_row_t dir_rows [22];
		attr_res_t none;
		logic [5:0] m;
		int phase_len;
		none = '0;
		dir_rows = '{
			'{6'd1,  64'hFF, 64'd0, 1'b1, '{32'h3F80_0000, 32'd0, 32'd0, 32'd0, 5'd1}},
			'{6'd1,  64'd0, 64'd0, 1'b1, '{32'd0, 32'd0, 32'd0, 32'd0, 5'd1}},
			'{6'd3,  64'h7F, 64'd0, 1'b1, '{32'h3F80_0000, 32'd0, 32'd0, 32'd0, 5'd1}},
			'{6'd3,  64'h80, 64'd0, 1'b0, '0},
			'{6'd7,  64'hFFFF, 64'd0, 1'b1, '{32'h3F80_0000, 32'd0, 32'd0, 32'd0, 5'd2}},
			'{6'd9,  64'h8000, 64'd0, 1'b0, '0},
			'{6'd33, 64'hFFFF_FFFF, 64'd0, 1'b1, '{32'h4F80_0000, 32'd0, 32'd0, 32'd0, 5'd4}},
			'{6'd34, 64'h8000_0000, 64'd0, 1'b1, '{32'hCF00_0000, 32'd0, 32'd0, 32'd0, 5'd4}},
			'{6'd35, 64'h7FC0_0001, 64'd0, 1'b1, '{32'h7FC0_0001, 32'd0, 32'd0, 32'd0, 5'd4}},
			'{6'd0,  64'h7FFF_FFFF, 64'd0, 1'b0, '0},
			'{6'd0,  64'h8020_0801, 64'd0, 1'b0, '0},
			'{6'd31, 64'h7E01_7C00, 64'd0, 1'b1, '{32'h7F80_0000, 32'h7FC0_2000, 32'd0, 32'd0,
				5'd4}},
			'{6'd32, 64'hFFFF_0001_8000_03FF, 64'd0, 1'b0, '0},
			'{6'd44, 64'hFFFF_FFFF_0000_0000, 64'h7F80_0000_8000_0000, 1'b1,
				'{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7F80_0000, 5'd16}},
			'{6'd42, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
			'{6'd43, 64'h8000_0000_7FFF_FFFF, 64'hFFFF_FFFF_0000_0001, 1'b0, '0},
			'{6'd21, 64'h8180_7F01, 64'd0, 1'b0, '0},
			'{6'd27, 64'h7FFF_8000, 64'd0, 1'b0, '0},
			'{6'd29, 64'h8001_FFFF, 64'd0, 1'b0, '0},
			'{6'd45, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
			'{6'd63, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
			'{6'd19, 64'hFF80_7F00, 64'd0, 1'b0, '0}
		};
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.mode <= '0;
		in_ch.raw_low <= '0;
		in_ch.raw_high <= '0;
		model_be = 1'b0;
		fail_cnt = 0;
		calm = 1'b0;
		stim_done = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, little-endian after reset, then again big-endian
		foreach (dir_rows[i])
			send_attr(dir_rows[i].mode, dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].typed_exp,
			          dir_rows[i].res);
		write_order(1'b1);
		foreach (dir_rows[i])
			send_attr(dir_rows[i].mode, dir_rows[i].lo, dir_rows[i].hi, 1'b0, none);

		// random attributes over several byte order phases
		phase_len = NumRandom / 4;
		for (int n = 0; n < NumRandom; n++) begin
			if (n != 0 && n % phase_len == 0 && n < NumRandom - CalmTail)
				write_order((n / phase_len) % 2 == 0 ? 1'b1 : 1'(model_be ^ $urandom_range(0, 1)));
			if (n >= NumRandom - CalmTail)
				calm = 1'b1;
			m = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(45, 63)) : 6'($urandom_range(0, 44));
			send_attr(m, rand_word(), rand_word(), 1'b0, none);
		end
		in_ch.valid <= 1'b0;
		stim_done = 1'b1;

		for (int c = 0; pending_attrs.size() != 0; c++) begin
			if (c > StallLimit) begin
				$display("FAILURE");
				$finish;
			end
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		if (fail_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
rtl/vau_pkg.sv
rtl/vau_if.sv
rtl/vau_lane.sv
rtl/vertex_attribute_unpack.sv
bench/tb_top.sv
